// File: sv/fpc_pkg.sv
// Shared types, constants and the CRC byte update for the framed packet checker.
`default_nettype none

package fpc_pkg;

    localparam logic [7:0]  MAGIC_VALUE    = 8'hFD;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [16:0] FRAME_OVERHEAD = 17'd11;
    localparam logic [16:0] SUM_INDEX      = 17'd8;
    localparam logic [16:0] COUNT_MAX      = 17'h1FFFF;
    localparam logic [16:0] IDX_MAGIC      = 17'd0;
    localparam logic [16:0] IDX_LEN_LO     = 17'd1;
    localparam logic [16:0] IDX_LEN_HI     = 17'd2;
    localparam logic [16:0] IDX_CRC_START  = 17'd3;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_MAGIC  = 3'd1,
        ST_BAD_LENGTH = 3'd2,
        ST_BAD_SUM    = 3'd3,
        ST_BAD_CRC    = 3'd4
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] payload_length;
    } fpc_result_t;

    // One byte of the reflected CRC-16 with polynomial 0x8408.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

endpackage

`default_nettype wire

// File: sv/framed_packet_checker.sv
// Top level of the framed packet checker: input register, frame state and result register.
//
// The block takes a received frame one byte per item on the slave stream, with tlast on
// the last byte, and checks the frame in this order: magic byte 0xFD at byte 0, the
// little-endian length in bytes 1 and 2 plus 11 against the bytes received, the 8-bit
// sum of bytes 0 to 7 against byte 8, and a reflected CRC-16 (init 0xFFFF, no final
// xor) over byte 1 to the third-last byte against the last two bytes, low byte first.
// For each frame one item leaves on the master stream: the first failed check as a
// status code and the declared payload length. Bytes other than the last give nothing.
// The last byte, once accepted, waits in the input register and is checked
// combinationally by the frame state on its way into the result register.
// Throughput: one byte per cycle, set by the combinational CRC byte update and compare,
// as long as the last byte of a frame finds the result register free.
// After reset all frame state is cleared, the CRC holds 0xFFFF and both streams are
// idle. When the receiver stalls, the result waits in the result register while bytes
// of the next frame keep flowing in; only that frame's last byte waits for the slot.
`default_nettype none

module framed_packet_checker
    import fpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tlast,   // frame_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // [2:0] status, [18:3] payload_length, rest zero
);

    // Input register.
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    // Result register.
    logic        out_valid_reg;
    fpc_result_t out_reg;

    fpc_result_t result;
    logic        out_free;
    logic        s1_move;

    // A byte that ends no frame never needs the result slot.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_move       = s1_valid_reg && (!s1_last_reg || out_free);
    assign s_axis_tready = !s1_valid_reg || s1_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            s1_byte_reg <= s_axis_tdata;
            s1_last_reg <= s_axis_tlast;
        end
    end

    fpc_frame_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_move),
        .rx_byte   (s1_byte_reg),
        .frame_end (s1_last_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_move && s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_move && s1_last_reg)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_reg.payload_length, out_reg.status};

    // A result only appears after a frame's last byte was taken into the state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s1_move && s1_last_reg))
        else $error("result raised without a frame end");

    // A last byte only moves on when the result slot is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_last_reg) |-> out_free)
        else $error("frame end moved while result slot was occupied");

    // A held input byte is neither lost nor replaced.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(s1_byte_reg)
                                        && $stable(s1_last_reg)))
        else $error("held input byte overwritten");

endmodule

`default_nettype wire

// File: sv/fpc_frame_state.sv
// Per-frame state of the packet checker and the combinational check of the last byte.
`default_nettype none

module fpc_frame_state
    import fpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_end,
    output fpc_result_t      result
);

    logic [16:0] count_reg,  count_next;
    logic [7:0]  magic_reg,  magic_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  sum_reg,    sum_next;
    logic [7:0]  check_reg,  check_next;
    logic [15:0] crc_reg,    crc_next;
    logic [7:0]  d0_reg,     d0_next;
    logic [7:0]  d1_reg,     d1_next;
    logic [15:0] trailer;

    always_comb
    begin
        magic_next  = magic_reg;
        length_next = length_reg;
        sum_next    = sum_reg;
        check_next  = check_reg;
        crc_next    = crc_reg;

        if (count_reg == IDX_MAGIC)
        begin
            magic_next = rx_byte;
        end
        else if (count_reg == IDX_LEN_LO)
        begin
            length_next = {length_reg[15:8], rx_byte};
        end
        else if (count_reg == IDX_LEN_HI)
        begin
            length_next = {rx_byte, length_reg[7:0]};
        end

        if (count_reg < SUM_INDEX)
        begin
            sum_next = sum_reg + rx_byte;
        end
        else if (count_reg == SUM_INDEX)
        begin
            check_next = rx_byte;
        end

        // The byte two places back enters the CRC, so the trailer never does.
        if (count_reg >= IDX_CRC_START)
        begin
            crc_next = crc_feed(crc_reg, d1_reg);
        end
        d1_next = d0_reg;
        d0_next = rx_byte;

        count_next = (count_reg < COUNT_MAX) ? count_reg + 17'd1 : count_reg;

        trailer = {d0_next, d1_next};

        if (magic_next != MAGIC_VALUE)
        begin
            result.status = ST_BAD_MAGIC;
        end
        else if ({1'b0, length_next} + FRAME_OVERHEAD != count_next)
        begin
            result.status = ST_BAD_LENGTH;
        end
        else if (sum_next != check_next)
        begin
            result.status = ST_BAD_SUM;
        end
        else if (crc_next != trailer)
        begin
            result.status = ST_BAD_CRC;
        end
        else
        begin
            result.status = ST_OK;
        end
        result.payload_length = length_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            magic_reg  <= '0;
            length_reg <= '0;
            sum_reg    <= '0;
            check_reg  <= '0;
            crc_reg    <= CRC_INIT;
            d0_reg     <= '0;
            d1_reg     <= '0;
        end
        else if (step)
        begin
            if (frame_end)
            begin
                count_reg  <= '0;
                magic_reg  <= '0;
                length_reg <= '0;
                sum_reg    <= '0;
                check_reg  <= '0;
                crc_reg    <= CRC_INIT;
                d0_reg     <= '0;
                d1_reg     <= '0;
            end
            else
            begin
                count_reg  <= count_next;
                magic_reg  <= magic_next;
                length_reg <= length_next;
                sum_reg    <= sum_next;
                check_reg  <= check_next;
                crc_reg    <= crc_next;
                d0_reg     <= d0_next;
                d1_reg     <= d1_next;
            end
        end
    end

endmodule

`default_nettype wire
